// ----- rtl/jtlf_pkg.sv -----
// Shared definitions for the job table with lowest-free-id assignment.
// Holds command and status codes, beat layouts and the types passed along the cell chain.
// Depends on nothing; used by jtlf_cell and job_table_lowest_free_id.
package jtlf_pkg;

    localparam int unsigned TABLE_SIZE_DEF = 16;
    localparam int unsigned TABLE_MAX      = 256;
    localparam int unsigned SLOT_W         = $clog2(TABLE_MAX);
    localparam int unsigned ID_W           = $clog2(TABLE_MAX + 1);

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned PID_W   = 22;
    localparam int unsigned STATE_W = 2;
    localparam int unsigned JID_W   = 5;
    localparam int unsigned STAT_W  = 2;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 56;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_PID  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_JID  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_PID = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND_JID = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND_FG  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    localparam logic [STATE_W-1:0] JOB_FOREGROUND = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [CMD_W-1:0]   cmd;
        logic [PID_W-1:0]   pid;
        logic [PID_W-1:0]   pgid;
        logic [STATE_W-1:0] state;
        logic [JID_W-1:0]   jid;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    f_id;
        logic [PID_W-1:0]   f_pid;
        logic [PID_W-1:0]   f_pgid;
        logic [STATE_W-1:0] f_state;
        logic               id_hit;
        logic [ID_W-1:0]    free_id;
    } probe_t;

    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [PID_W-1:0]   pid;
        logic [PID_W-1:0]   pgid;
        logic [STATE_W-1:0] state;
    } upd_t;

endpackage

// ----- rtl/jtlf_cell.sv -----
// One slot of the job table: holds an entry and a used-id flag view, and passes the search probe on.
// The probe picks up the first matching slot and the first unused id as it moves down the chain.
// Depends on jtlf_pkg.
module jtlf_cell #(
    parameter logic [jtlf_pkg::SLOT_W-1:0] CELL_IDX = '0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  jtlf_pkg::probe_t probe_in,
    input  logic             id_used,
    input  jtlf_pkg::upd_t   upd,
    output jtlf_pkg::probe_t probe_out
);
    import jtlf_pkg::*;

    logic [ID_W-1:0]    id_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [PID_W-1:0]   pgid_reg;
    logic [STATE_W-1:0] state_reg;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic               occupied;
    logic               match;

    assign occupied = (id_reg != '0);

    always_comb begin
        unique case (probe_in.cmd)
            CMD_ADD:                   match = !occupied;
            CMD_DEL_PID, CMD_FIND_PID: match = occupied && (pid_reg == probe_in.pid);
            CMD_DEL_JID, CMD_FIND_JID: match = occupied && (id_reg == ID_W'(probe_in.jid));
            CMD_FIND_FG:               match = occupied && (state_reg == JOB_FOREGROUND);
            default:                   match = 1'b0;
        endcase
    end

    always_comb begin
        probe_next = probe_in;
        if (!probe_in.hit && match) begin
            probe_next.hit     = 1'b1;
            probe_next.slot    = CELL_IDX;
            probe_next.f_id    = id_reg;
            probe_next.f_pid   = pid_reg;
            probe_next.f_pgid  = pgid_reg;
            probe_next.f_state = state_reg;
        end
        if (!probe_in.id_hit && !id_used) begin
            probe_next.id_hit  = 1'b1;
            probe_next.free_id = ID_W'(CELL_IDX) + ID_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_reg <= '0;
        end else if (upd.we && (upd.slot == CELL_IDX)) begin
            id_reg <= upd.id;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.we && (upd.slot == CELL_IDX)) begin
            pid_reg   <= upd.pid;
            pgid_reg  <= upd.pgid;
            state_reg <= upd.state;
        end
    end

    assign probe_out = probe_reg;

endmodule

// ----- rtl/job_table_lowest_free_id.sv -----
// Job table with lowest-free-id assignment: top level with the cell chain, id map and result beat.
// The result beat is registered once the probe has left the last cell of the chain.
// The probe walks the cell chain one cell a cycle, since every cell registers it.
// The table takes one command at a time; the next beat is accepted once the result is taken.
// Reset (aresetn low, synchronous) frees every slot and every id at once; no clearing pass.
// Depends on jtlf_pkg and jtlf_cell.
module job_table_lowest_free_id #(
    parameter int unsigned TABLE_SIZE = jtlf_pkg::TABLE_SIZE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // command[2:0], pid[24:3], pgid[46:25], run_state[48:47], jid[53:49], zero pad
    input  logic [jtlf_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status[1:0], found_jid[6:2], found_pid[28:7], found_pgid[50:29], found_state[52:51], pad
    output logic [jtlf_pkg::M_TDATA_W-1:0]     m_tdata
);
    import jtlf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_OUT  = 3'b100
    } fsm_t;

    fsm_t                   state_reg;
    fsm_t                   state_next;
    probe_t                 probe [TABLE_SIZE+1];
    logic [TABLE_SIZE:0]    chain_valid;
    logic [TABLE_SIZE-1:0]  used_reg;
    logic [TABLE_SIZE-1:0]  used_next;
    upd_t                   upd;
    probe_t                 exit_p;
    logic                   s_accept;
    logic                   id_set;
    logic                   id_clr;
    logic [STAT_W-1:0]      res_status;
    logic [JID_W-1:0]       res_jid;
    logic [PID_W-1:0]       res_pid;
    logic [PID_W-1:0]       res_pgid;
    logic [STATE_W-1:0]     res_state;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TDATA_W-1:0]   m_tdata_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign exit_p   = probe[TABLE_SIZE];

    always_comb begin
        probe[0]       = '0;
        probe[0].valid = s_accept;
        probe[0].cmd   = s_tdata[2:0];
        probe[0].pid   = s_tdata[24:3];
        probe[0].pgid  = s_tdata[46:25];
        probe[0].state = s_tdata[48:47];
        probe[0].jid   = s_tdata[53:49];
    end

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_cell
        jtlf_cell #(
            .CELL_IDX (SLOT_W'(k))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .probe_in  (probe[k]),
            .id_used   (used_reg[k]),
            .upd       (upd),
            .probe_out (probe[k+1])
        );
    end

    for (genvar k = 0; k <= TABLE_SIZE; k++) begin : g_valid
        assign chain_valid[k] = probe[k].valid;
    end

    always_comb begin
        upd        = '0;
        id_set     = 1'b0;
        id_clr     = 1'b0;
        res_status = STAT_NOMATCH;
        res_jid    = '0;
        res_pid    = '0;
        res_pgid   = '0;
        res_state  = '0;
        if (exit_p.valid) begin
            if (exit_p.cmd == CMD_ADD) begin
                if (exit_p.hit && exit_p.id_hit) begin
                    res_status = STAT_OK;
                    res_jid    = exit_p.free_id[JID_W-1:0];
                    upd.we     = 1'b1;
                    upd.slot   = exit_p.slot;
                    upd.id     = exit_p.free_id;
                    upd.pid    = exit_p.pid;
                    upd.pgid   = exit_p.pgid;
                    upd.state  = exit_p.state;
                    id_set     = 1'b1;
                end else begin
                    res_status = STAT_FULL;
                end
            end else if (exit_p.hit) begin
                res_status = STAT_OK;
                res_jid    = exit_p.f_id[JID_W-1:0];
                res_pid    = exit_p.f_pid;
                res_pgid   = exit_p.f_pgid;
                res_state  = exit_p.f_state;
                if (exit_p.cmd == CMD_DEL_PID || exit_p.cmd == CMD_DEL_JID) begin
                    upd.we   = 1'b1;
                    upd.slot = exit_p.slot;
                    id_clr   = 1'b1;
                end
            end
        end
    end

    always_comb begin
        used_next = used_reg;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (id_set && (exit_p.free_id == ID_W'(i + 1))) begin
                used_next[i] = 1'b1;
            end
            if (id_clr && (exit_p.f_id == ID_W'(i + 1))) begin
                used_next[i] = 1'b0;
            end
        end
    end

    assign m_tdata_next = {3'b000, res_state, res_pgid, res_pid, res_jid, res_status};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (exit_p.valid) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exit_p.valid) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = m_tdata_reg;

    a_single_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_valid))
        else $error("More than one command is walking the cell chain.");

    a_probe_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> probe[1].valid)
        else $error("An accepted command did not enter the first cell.");

    a_result_from_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(exit_p.valid))
        else $error("A result beat appeared without a command leaving the chain.");

    a_add_free_id: assert property (@(posedge aclk) disable iff (!aresetn)
        id_set |-> ($countones(used_next) == $countones(used_reg) + 1))
        else $error("An add handed out an id that was already in use.");

endmodule
